// ----- rtl/core/erghd_pkg.sv -----
// Shared types and constants for the engine-run logging gate.
// Holds event codes, configuration register indexes and reset values.
// No dependencies.
package erghd_pkg;

  // Default width of timestamps, in bits
  localparam int unsigned TimeWidthDflt = 48;

  // Microseconds per millisecond for the off-debounce scaling
  localparam int unsigned UsPerMs    = 1000;
  localparam int unsigned MsWidth    = 16;
  localparam int unsigned DbncUsWidth = MsWidth + 10;

  localparam int unsigned MvWidth    = 16;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned OutDataWidth = 8;

  // Configuration reset values
  localparam logic [MvWidth-1:0]    OpenThrRst   = 16'd13200;
  localparam logic [MvWidth-1:0]    HystRst      = 16'd500;
  localparam logic [MsWidth-1:0]    OffDbncRst   = 16'd5000;
  localparam logic                  RpmPresRst   = 1'b0;
  localparam logic [CountWidth-1:0] ConfirmRst   = 4'd3;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvWait  = 2'd1,
    EvOpen  = 2'd2,
    EvClose = 2'd3
  } event_e;

  typedef enum logic [CfgAddrWidth-1:0] {
    CfgOpenThr  = 3'd0,
    CfgHyst     = 3'd1,
    CfgOffDbnc  = 3'd2,
    CfgRpmPres  = 3'd3,
    CfgConfirm  = 3'd4
  } cfg_idx_e;

  // One result word
  typedef struct packed {
    logic   sweep_fast;
    logic   gate_is_open;
    logic   closed_by_rpm;
    event_e event_res;
  } result_t;

endpackage

// ----- rtl/core/engine_run_gate_hysteresis_debounce_core.sv -----
// Engine-run logging gate: voltage hysteresis, rpm confirmation, off-debounce.
// Depends on erghd_pkg.
//
// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+-------------------------------------
// s_axis    | in  | tvalid / tready        | tdata: evaluation inputs, tuser: action
// m_axis    | out | tvalid / tready        | tdata: event, rpm close, gate, sweep
// cfg       | in  | cfg_valid / cfg_ready  | cfg_addr: register index, cfg_data
//
// Rate: one word per clock while m_axis_tready is high; each input word taken
// passes the input register, then the decision into the result register.
// Reset: rst_ni clears the gate state and loads the configuration defaults.
// Stalls: while a result waits on m_axis_tready, one more input word is held
// in the input register; s_axis_tready drops only when both are full.
// The debounce limit in microseconds is registered from its millisecond
// register, in the cycle after that register is written.
module engine_run_gate_hysteresis_debounce_core
  import erghd_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDflt,
  localparam int unsigned InDataWidth = ((TIME_WIDTH + 21 + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // tdata, low bit up: time_us, volts_valid, volts_mv, rpm_fresh,
  // rpm_says_running, ecu_responding, session_on, zero fill
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // tuser: action
  input  logic                    s_axis_tuser,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata, low bit up: event_res[1:0], closed_by_rpm, gate_is_open,
  // sweep_fast, zero fill
  output logic [OutDataWidth-1:0] m_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  // Field positions inside s_axis_tdata
  localparam int unsigned VvPos   = TIME_WIDTH;
  localparam int unsigned MvLo    = TIME_WIDTH + 1;
  localparam int unsigned FrPos   = MvLo + MvWidth;
  localparam int unsigned RunPos  = FrPos + 1;
  localparam int unsigned EcuPos  = FrPos + 2;
  localparam int unsigned SessPos = FrPos + 3;

  // Configuration registers
  logic [MvWidth-1:0]     open_thr_q;
  logic [MvWidth-1:0]     hyst_q;
  logic [MsWidth-1:0]     off_dbnc_q;
  logic                   rpm_pres_q;
  logic [CountWidth-1:0]  confirm_q;
  logic [DbncUsWidth-1:0] dbnc_us_q;

  // Pipeline registers
  logic                   in_valid_q;
  logic                   in_action_q;
  logic [InDataWidth-1:0] in_data_q;
  logic                   out_valid_q;
  result_t                out_q;
  result_t                out_d;

  // Gate state
  logic                   open_q, open_d;
  logic [TIME_WIDTH-1:0]  low_start_q, low_start_d;
  logic [CountWidth-1:0]  wait_cnt_q, wait_cnt_d;

  logic advance;
  logic take_in;

  // Move the decision stage when the result register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_thr_q <= OpenThrRst;
      hyst_q     <= HystRst;
      off_dbnc_q <= OffDbncRst;
      rpm_pres_q <= RpmPresRst;
      confirm_q  <= ConfirmRst;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CfgOpenThr: open_thr_q <= cfg_data_i[MvWidth-1:0];
        CfgHyst:    hyst_q     <= cfg_data_i[MvWidth-1:0];
        CfgOffDbnc: off_dbnc_q <= cfg_data_i[MsWidth-1:0];
        CfgRpmPres: rpm_pres_q <= cfg_data_i[0];
        CfgConfirm: confirm_q  <= cfg_data_i[CountWidth-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Scale the debounce to microseconds off the decision path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbnc_us_q <= DbncUsWidth'(OffDbncRst) * DbncUsWidth'(UsPerMs);
    end else begin
      dbnc_us_q <= DbncUsWidth'(off_dbnc_q) * DbncUsWidth'(UsPerMs);
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_action_q <= s_axis_tuser;
      in_data_q   <= s_axis_tdata;
    end
  end

  // Decision logic
  logic [TIME_WIDTH-1:0] now;
  logic [MvWidth-1:0]    volts;
  logic                  have_v, fresh, running, ecu, session;
  logic [MvWidth-1:0]    line;
  logic                  volt_ok, rpm_ok, rpm_pos;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  expired;

  assign now     = in_data_q[TIME_WIDTH-1:0];
  assign have_v  = in_data_q[VvPos];
  assign volts   = in_data_q[MvLo +: MvWidth];
  assign fresh   = in_data_q[FrPos];
  assign running = in_data_q[RunPos];
  assign ecu     = in_data_q[EcuPos];
  assign session = in_data_q[SessPos];

  always_comb begin
    // Lower the line by the hysteresis band while open, floor at zero
    if (!open_q) begin
      line = open_thr_q;
    end else if (hyst_q >= open_thr_q) begin
      line = '0;
    end else begin
      line = open_thr_q - hyst_q;
    end
  end

  assign volt_ok = !have_v || (volts >= line);
  assign rpm_ok  = !fresh || running;
  assign rpm_pos = !rpm_pres_q || (fresh && running);
  assign elapsed = now - low_start_q;
  assign expired = (now >= low_start_q) &&
                   (elapsed > TIME_WIDTH'(dbnc_us_q));

  always_comb begin
    open_d            = open_q;
    low_start_d       = low_start_q;
    wait_cnt_d        = wait_cnt_q;
    out_d.event_res   = EvNone;
    out_d.closed_by_rpm = 1'b0;

    if (in_action_q) begin
      // Force close: clear everything
      open_d      = 1'b0;
      low_start_d = '0;
      wait_cnt_d  = '0;
    end else if (!open_q) begin
      if (ecu && volt_ok && rpm_ok) begin
        if (rpm_pres_q && !fresh && (wait_cnt_q < confirm_q)) begin
          // Stale rpm: wait another pass for a fresh sample
          wait_cnt_d      = wait_cnt_q + 1'b1;
          out_d.event_res = EvWait;
        end else begin
          open_d          = 1'b1;
          low_start_d     = '0;
          wait_cnt_d      = '0;
          out_d.event_res = EvOpen;
        end
      end else if (fresh) begin
        wait_cnt_d = '0;
      end
    end else begin
      wait_cnt_d = '0;
      if (volt_ok && rpm_pos) begin
        low_start_d = '0;
      end else if (volt_ok && rpm_pres_q && !fresh) begin
        // Stale rpm sample: hold the debounce timer
      end else if (low_start_q == '0) begin
        low_start_d = now;
      end else if (expired) begin
        open_d              = 1'b0;
        low_start_d         = '0;
        out_d.closed_by_rpm = !rpm_ok;
        out_d.event_res     = EvClose;
      end
    end

    out_d.gate_is_open = open_d;
    out_d.sweep_fast   = open_d || session;
  end

  // Commit state and result together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      low_start_q <= '0;
      wait_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        open_q      <= open_d;
        low_start_q <= low_start_d;
        wait_cnt_q  <= wait_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataWidth'(out_q);

endmodule

// ----- rtl/core/erghd_checker.sv -----
// Port-level checks for the engine-run logging gate.
// Depends on erghd_pkg; bound to engine_run_gate_hysteresis_debounce_core.
module erghd_checker
  import erghd_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic [OutDataWidth-1:0] m_axis_tdata,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready
);

  result_t res;
  assign res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

  // Hold a stalled result word
  property p_stall_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata));
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("result changed under stall");

  // Opening leaves the gate open, closing leaves it shut
  property p_event_gate;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |->
        ((res.event_res != EvOpen) || res.gate_is_open) &&
        ((res.event_res != EvClose) || !res.gate_is_open);
  endproperty
  a_event_gate: assert property (p_event_gate) else $error("event and gate disagree");

  // An rpm close flag only comes with a close event
  property p_rpm_close;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && res.closed_by_rpm) |-> (res.event_res == EvClose);
  endproperty
  a_rpm_close: assert property (p_rpm_close) else $error("rpm close without close event");

  // An open gate always asks for fast sweeping
  property p_sweep;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && res.gate_is_open) |-> res.sweep_fast;
  endproperty
  a_sweep: assert property (p_sweep) else $error("open gate without fast sweep");

endmodule

bind engine_run_gate_hysteresis_debounce_core erghd_checker u_erghd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ----- tb/sv/engine_run_gate_hysteresis_debounce_core_test.sv -----
// Self-checking bench for the engine-run logging gate core.
// Drives evaluation words and register writes, predicts every result word.
// Depends on erghd_pkg and engine_run_gate_hysteresis_debounce_core.
`timescale 1ns / 1ps

module engine_run_gate_hysteresis_debounce_core_test;
  import erghd_pkg::*;

  localparam int unsigned TimeW        = TimeWidthDflt;
  localparam int unsigned InW          = ((TimeW + 21 + 7) / 8) * 8;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned RandPerPhase = 110;
  localparam int unsigned NumPhases    = 8;
  // Indexes past the last register; the core must ignore writes to them
  localparam logic [CfgAddrWidth-1:0] CfgSpareLo = 3'd5;
  localparam logic [CfgAddrWidth-1:0] CfgSpareHi = 3'd7;

  // One evaluation word as the sender sees it
  typedef struct packed {
    logic             action;
    logic [TimeW-1:0] time_us;
    logic             volts_valid;
    logic [MvWidth-1:0] volts_mv;
    logic             rpm_fresh;
    logic             rpm_run;
    logic             ecu_ok;
    logic             session_on;
  } eval_word_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  // tdata, low bit up: time_us, volts_valid, volts_mv, rpm_fresh,
  // rpm_says_running, ecu_responding, session_on, zero fill
  logic [InW-1:0]          s_axis_tdata  = '0;
  // tuser: action
  logic                    s_axis_tuser  = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // tdata, low bit up: event_res[1:0], closed_by_rpm, gate_is_open,
  // sweep_fast, zero fill
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgAddrWidth-1:0] cfg_addr_i    = '0;
  logic [CfgDataWidth-1:0] cfg_data_i    = '0;

  // Predicted configuration, updated on every accepted register write
  logic [MvWidth-1:0]    thr_mv      = OpenThrRst;
  logic [MvWidth-1:0]    hyst_mv     = HystRst;
  logic [MsWidth-1:0]    off_ms      = OffDbncRst;
  logic                  rpm_chan    = RpmPresRst;
  logic [CountWidth-1:0] confirm_lim = ConfirmRst;

  // Predicted gate state
  logic                  pred_open   = 1'b0;
  logic [TimeW-1:0]      low_since   = '0;
  logic [CountWidth-1:0] stale_waits = '0;

  eval_word_t  eval_word_q[$];     // words waiting for the driver
  result_t     gate_result_q[$];   // predicted result words, oldest first
  eval_word_t  cur_word;           // word currently offered on s_axis
  logic        in_taken      = 1'b0;
  int unsigned words_queued  = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [TimeW-1:0] clock_us = '0; // running timestamp for random words

  engine_run_gate_hysteresis_debounce_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Advance the predicted gate by one evaluation word and return its result.
  function automatic result_t gate_decision(eval_word_t w);
    logic [MvWidth-1:0] line;
    logic               volt_ok;
    logic               rpm_ok;
    logic               rpm_pos;
    logic [63:0]        hold_us;
    result_t            r;
    r.event_res     = EvNone;
    r.closed_by_rpm = 1'b0;
    if (w.action) begin
      pred_open   = 1'b0;
      low_since   = '0;
      stale_waits = '0;
    end else begin
      // Lower the line by the band while open, never below zero
      line = thr_mv;
      if (pred_open) line = (hyst_mv >= thr_mv) ? '0 : thr_mv - hyst_mv;
      volt_ok = !w.volts_valid || (w.volts_mv >= line);
      rpm_ok  = !w.rpm_fresh || w.rpm_run;
      rpm_pos = !rpm_chan || (w.rpm_fresh && w.rpm_run);
      hold_us = 64'(off_ms) * UsPerMs;
      if (!pred_open) begin
        if (w.ecu_ok && volt_ok && rpm_ok) begin
          // Give a stale rpm channel a bounded number of passes first
          if (rpm_chan && !w.rpm_fresh && stale_waits < confirm_lim) begin
            stale_waits = stale_waits + 1'b1;
            r.event_res = EvWait;
          end else begin
            pred_open   = 1'b1;
            low_since   = '0;
            stale_waits = '0;
            r.event_res = EvOpen;
          end
        end else if (w.rpm_fresh) begin
          stale_waits = '0;
        end
      end else begin
        stale_waits = '0;
        if (volt_ok && rpm_pos) begin
          low_since = '0;
        end else if (!(volt_ok && rpm_chan && !w.rpm_fresh)) begin
          // Zero marks "not low yet", so a low pass at time zero re-marks
          if (low_since == '0) begin
            low_since = w.time_us;
          end else if (w.time_us >= low_since &&
                       64'(w.time_us - low_since) > hold_us) begin
            pred_open       = 1'b0;
            low_since       = '0;
            r.closed_by_rpm = !rpm_ok;
            r.event_res     = EvClose;
          end
        end
        // A stale sample with good voltage holds the debounce timer
      end
    end
    r.gate_is_open = pred_open;
    r.sweep_fast   = pred_open | w.session_on;
    return r;
  endfunction

  function automatic eval_word_t eval_word(logic a, logic [TimeW-1:0] t, logic vv,
                                           logic [MvWidth-1:0] mv, logic f, logic rn,
                                           logic e, logic s);
    return {a, t, vv, mv, f, rn, e, s};
  endfunction

  task automatic queue_word(eval_word_t w);
    eval_word_q.push_back(w);
    words_queued++;
  endtask

  // Queue random words shaped around the current thresholds and debounce.
  task automatic queue_random(int unsigned n);
    eval_word_t  w;
    int unsigned pick;
    int          mv;
    longint unsigned hold_us;
    for (int unsigned k = 0; k < n; k++) begin
      hold_us = 64'(off_ms) * UsPerMs;
      pick = $urandom_range(99);
      // Mostly small steps inside the debounce, some past it, a few odd jumps
      if (pick < 60) begin
        clock_us += $urandom_range(0, 32'(hold_us / 3) + 50);
      end else if (pick < 85) begin
        clock_us += 32'(hold_us) + $urandom_range(1, 3000);
      end else if (pick < 92) begin
        clock_us -= $urandom_range(0, 4000);
      end else if (pick < 96) begin
        clock_us = '0;
      end else begin
        clock_us = TimeW'({$urandom, $urandom});
      end
      w.time_us = clock_us;
      w.action  = ($urandom_range(99) < 3);
      pick = $urandom_range(99);
      if (pick < 60) begin
        // Hover around either the open line or the close line
        mv = ($urandom_range(1) ? int'(thr_mv) : int'(thr_mv) - int'(hyst_mv))
             + int'($urandom_range(0, 600)) - 300;
        if (mv < 0) mv = 0;
        if (mv > 65535) mv = 65535;
      end else if (pick < 85) begin
        mv = $urandom_range(0, 65535);
      end else begin
        mv = $urandom_range(1) ? 65535 : 0;
      end
      w.volts_mv    = mv[MvWidth-1:0];
      w.volts_valid = ($urandom_range(99) < 85);
      w.rpm_fresh   = ($urandom_range(99) < 70);
      w.rpm_run     = ($urandom_range(99) < 75);
      w.ecu_ok      = ($urandom_range(99) < 85);
      w.session_on  = ($urandom_range(1) != 0);
      queue_word(w);
    end
  endtask

  // Present one register write and hold it until the core takes it.
  task automatic write_reg(logic [CfgAddrWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Wait until every queued word has produced its result, then let the
  // two-stage pipeline settle.
  task automatic drain();
    do @(negedge clk_i); while (results_seen != words_queued);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Driver: offer the next pending word at the falling edge; hold the
  // current word until it is taken. Stall the result side at random too.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (eval_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = eval_word_q.pop_front();
          s_axis_tdata  <= InW'({cur_word.session_on, cur_word.ecu_ok,
                                 cur_word.rpm_run, cur_word.rpm_fresh,
                                 cur_word.volts_mv, cur_word.volts_valid,
                                 cur_word.time_us});
          s_axis_tuser  <= cur_word.action;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check result words, predict accepted words, track register
  // writes. Everything is sampled at the rising edge.
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (gate_result_q.size() == 0) begin
          $error("result word %h with no prediction pending", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = gate_result_q.pop_front();
          results_seen++;
          if (got.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
            mismatch_cnt++;
          end
          if (got.closed_by_rpm !== want.closed_by_rpm) begin
            $error("closed_by_rpm: expected %0d, got %0d",
                   want.closed_by_rpm, got.closed_by_rpm);
            mismatch_cnt++;
          end
          if (got.gate_is_open !== want.gate_is_open) begin
            $error("gate_is_open: expected %0d, got %0d",
                   want.gate_is_open, got.gate_is_open);
            mismatch_cnt++;
          end
          if (got.sweep_fast !== want.sweep_fast) begin
            $error("sweep_fast: expected %0d, got %0d", want.sweep_fast, got.sweep_fast);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        gate_result_q.push_back(gate_decision(cur_word));
        in_taken = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          CfgOpenThr: thr_mv      = cfg_data_i;
          CfgHyst:    hyst_mv     = cfg_data_i;
          CfgOffDbnc: off_ms      = cfg_data_i;
          CfgRpmPres: rpm_chan    = cfg_data_i[0];
          CfgConfirm: confirm_lim = cfg_data_i[CountWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("engine_run_gate_hysteresis_debounce_core verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned             ph;
    logic [CfgDataWidth-1:0] v[5];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under reset defaults (no rpm channel, 5 s debounce).
    queue_word(eval_word(1, 0, 0, 0, 0, 0, 0, 1));          // force close, session on
    queue_word(eval_word(0, 100, 1, 13200, 0, 0, 0, 0));    // ECU silent
    queue_word(eval_word(0, 200, 1, 13199, 0, 0, 1, 0));    // just under the open line
    queue_word(eval_word(0, 300, 1, 13200, 1, 0, 1, 0));    // fresh rpm says stopped
    queue_word(eval_word(0, 0, 0, 0, 0, 0, 1, 0));          // no voltage: fail open
    queue_word(eval_word(0, 0, 1, 12700, 0, 0, 1, 0));      // exactly on the close line
    queue_word(eval_word(0, 0, 1, 12699, 0, 0, 1, 0));      // low seen at time zero
    queue_word(eval_word(0, 0, 1, 12699, 0, 0, 1, 0));      // re-marked at time zero
    queue_word(eval_word(0, 1000, 1, 12699, 0, 0, 1, 0));   // mark low start
    queue_word(eval_word(0, 500, 1, 12699, 0, 0, 1, 0));    // time goes backwards
    queue_word(eval_word(0, 5001000, 1, 12699, 1, 1, 1, 0)); // debounce exactly reached
    queue_word(eval_word(0, 5001001, 1, 12699, 1, 0, 1, 1)); // close, caused by rpm
    queue_word(eval_word(0, '1, 1, 16'hFFFF, 1, 1, 1, 1));  // reopen at max time
    queue_word(eval_word(0, '1, 1, 0, 0, 0, 1, 0));         // low start at max time
    queue_word(eval_word(0, 0, 1, 0, 0, 0, 1, 0));          // wrapped time: no close
    queue_word(eval_word(1, '1, 1, 16'hFFFF, 1, 1, 1, 1));  // force close, all set
    queue_word(eval_word(0, 2000, 1, 13500, 1, 1, 1, 0));   // open again
    queue_word(eval_word(0, 3000, 1, 100, 0, 0, 0, 0));     // low while open
    queue_word(eval_word(0, 4000, 1, 12800, 0, 0, 0, 0));   // recovered: drop low start
    queue_word(eval_word(0, 5000, 1, 100, 0, 0, 1, 0));     // low again
    queue_word(eval_word(0, 5005001, 1, 100, 0, 0, 1, 0));  // close, not by rpm
    queue_word(eval_word(1, 0, 0, 0, 0, 0, 0, 0));          // quiet force close

    for (ph = 1; ph <= NumPhases; ph++) begin
      drain();
      case (ph)
        1: v = '{16'd13200, 16'd500, 16'd3, 16'd1, 16'd3};
        2: v = '{16'd0, 16'd0, 16'd0, 16'hFFFE, 16'hFFF0};          // floors, masked bits
        3: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}; // ceilings
        4: v = '{16'd1000, 16'd4000, 16'd1, 16'd1, 16'd15};        // close line clamps
        default: v = '{16'($urandom_range(9000, 15000)), 16'($urandom_range(0, 2000)),
                       16'($urandom_range(0, 20)), 16'($urandom_range(0, 1)),
                       16'($urandom_range(0, 15))};
      endcase
      // Poke the unused indexes now and then; they must not alias a register
      if (ph == 1 || ph == 5) begin
        for (int a = CfgSpareLo; a <= CfgSpareHi; a++)
          write_reg(a[CfgAddrWidth-1:0], 16'($urandom));
      end
      write_reg(CfgOpenThr, v[0]);
      write_reg(CfgHyst, v[1]);
      write_reg(CfgOffDbnc, v[2]);
      write_reg(CfgRpmPres, v[3]);
      write_reg(CfgConfirm, v[4]);
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      // The core registers the debounce in microseconds in the cycle after the write
      repeat (2) @(negedge clk_i);
      case (ph % 4)
        1: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        3: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      queue_random(RandPerPhase);
    end

    drain();
    if (mismatch_cnt == 0 && gate_result_q.size() == 0) begin
      $display("engine_run_gate_hysteresis_debounce_core verification clean");
    end else begin
      $display("engine_run_gate_hysteresis_debounce_core verification failed");
    end
    $finish;
  end

endmodule
